[hw/rtl/assert_macros.svh]
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TBGA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define TBGA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBGA_ASSERT(lbl, clk, rstn, prop, msg)
`define TBGA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/tbga_pkg.sv]
`default_nettype none
package tbga_pkg;
    localparam int POS_W    = 32;
    localparam int MAG_W    = 32;              // |p_j - p_i| < 2^32
    localparam int GM_W     = 64;              // G * m
    localparam int SUM_W    = 66;              // dx^2 + dy^2, padded to even
    localparam int ROOT_W   = SUM_W / 2;
    localparam int CUBE_W   = 3 * ROOT_W;
    localparam int PROD_W   = GM_W + MAG_W;    // G * m * |d|
    localparam int ADDR_W   = 4;
    localparam int NUM_QUO  = 4;
    localparam int NUM_ACC  = 6;
    localparam int NUM_TERMS = 2;
    localparam int NUM_PAIRS = 3;

    // quotient slots of one pair lane
    localparam int QX_A = 0;
    localparam int QY_A = 1;
    localparam int QX_B = 2;
    localparam int QY_B = 3;

    localparam logic [1:0] REG_MASS_ONE   = 2'd0;
    localparam logic [1:0] REG_MASS_TWO   = 2'd1;
    localparam logic [1:0] REG_MASS_THREE = 2'd2;
    localparam logic [1:0] REG_GRAV       = 2'd3;

    localparam logic [31:0] RESET_ONE = 32'h0001_0000;
    localparam logic [POS_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] ACC_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x_one;
        logic signed [POS_W-1:0] pos_y_one;
        logic signed [POS_W-1:0] pos_x_two;
        logic signed [POS_W-1:0] pos_y_two;
        logic signed [POS_W-1:0] pos_x_three;
        logic signed [POS_W-1:0] pos_y_three;
    } t_req;

    typedef struct packed {
        logic signed [POS_W-1:0] acc_x_one;
        logic signed [POS_W-1:0] acc_y_one;
        logic signed [POS_W-1:0] acc_x_two;
        logic signed [POS_W-1:0] acc_y_two;
        logic signed [POS_W-1:0] acc_x_three;
        logic signed [POS_W-1:0] acc_y_three;
        logic                    collision_flag;
        logic                    saturated_flag;
    } t_res;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_pair_flags;
endpackage
`default_nettype wire

[hw/rtl/three_body_gravity_accel.sv]
`default_nettype none
`include "assert_macros.svh"
// Planar three-body gravitational acceleration.
// Request channel: drive i_req (three signed positions) and pulse start; a
// request is taken at any clock edge with start high and busy low. busy
// stays low, so a new request can enter every cycle.
// Result channel: o_res_valid is high for one cycle with o_res holding the
// six saturated accelerations plus collision and saturation flags. Results
// come out in request order and cannot be held off by the receiver.
// Pipeline: the lane's front stages, the 33-stage square root, the
// three-stage cube, the bit-per-stage divider, 96 + FRAC_BITS stages long,
// and the merge. Throughput is one request per cycle.
// Three pair lanes share the distance work between both bodies of a pair;
// a two-stage merge sums and saturates each body's two pulls.
// Configuration: APB registers mass_one, mass_two, mass_three and
// grav_const at byte addresses 0, 4, 8, 12, each 1.0 after reset. Write
// them only with no request in flight.
// Reset (i_rst_n low, synchronous) drops requests in flight and restores
// the registers.
module three_body_gravity_accel import tbga_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_req,
    output logic                   o_res_valid,
    output t_res                   o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int QW    = PROD_W + FRAC_BITS;
    localparam int VLD_N = ROOT_W + 6 + QW;
    localparam int LAT   = VLD_N + 2;
    localparam logic [31:0] UNIT_VAL = 32'd1 << FRAC_BITS;

    logic [31:0]       r_mass [NUM_PAIRS];
    logic [31:0]       r_grav;
    logic [GM_W-1:0]   r_gm   [NUM_PAIRS];
    logic [VLD_N-1:0]  r_vld;
    logic              accept;

    logic [QW-1:0]     w_q  [NUM_PAIRS][NUM_QUO];
    t_pair_flags       w_fl [NUM_PAIRS];
    logic [QW-1:0]     m_mag  [NUM_ACC][NUM_TERMS];
    logic              m_neg  [NUM_ACC][NUM_TERMS];
    logic              m_zero [NUM_PAIRS];
    logic              at_limit;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass[0] <= UNIT_VAL;
            r_mass[1] <= UNIT_VAL;
            r_mass[2] <= UNIT_VAL;
            r_grav    <= UNIT_VAL;
            r_vld     <= '0;
        end else begin
            r_vld <= {r_vld[VLD_N-2:0], accept};
            if (psel && penable && pwrite) begin
                unique case (paddr[ADDR_W-1:2])
                    REG_MASS_ONE:   r_mass[0] <= pwdata;
                    REG_MASS_TWO:   r_mass[1] <= pwdata;
                    REG_MASS_THREE: r_mass[2] <= pwdata;
                    REG_GRAV:       r_grav    <= pwdata;
                endcase
            end
        end
    end

    // G*m stays static while requests are in flight only if the user writes no register then
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
            r_gm[k] <= r_grav * r_mass[k];
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_MASS_ONE:   prdata = r_mass[0];
            REG_MASS_TWO:   prdata = r_mass[1];
            REG_MASS_THREE: prdata = r_mass[2];
            REG_GRAV:       prdata = r_grav;
        endcase
    end

    tbga_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_12 (
        .i_clk  (i_clk),
        .i_pa_x (i_req.pos_x_one),
        .i_pa_y (i_req.pos_y_one),
        .i_pb_x (i_req.pos_x_two),
        .i_pb_y (i_req.pos_y_two),
        .i_gm_a (r_gm[0]),
        .i_gm_b (r_gm[1]),
        .o_quo  (w_q[0]),
        .o_flags(w_fl[0])
    );

    tbga_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_13 (
        .i_clk  (i_clk),
        .i_pa_x (i_req.pos_x_one),
        .i_pa_y (i_req.pos_y_one),
        .i_pb_x (i_req.pos_x_three),
        .i_pb_y (i_req.pos_y_three),
        .i_gm_a (r_gm[0]),
        .i_gm_b (r_gm[2]),
        .o_quo  (w_q[1]),
        .o_flags(w_fl[1])
    );

    tbga_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_23 (
        .i_clk  (i_clk),
        .i_pa_x (i_req.pos_x_two),
        .i_pa_y (i_req.pos_y_two),
        .i_pb_x (i_req.pos_x_three),
        .i_pb_y (i_req.pos_y_three),
        .i_gm_a (r_gm[1]),
        .i_gm_b (r_gm[2]),
        .o_quo  (w_q[2]),
        .o_flags(w_fl[2])
    );

    // the second body of a pair sees the difference vector reversed
    always_comb begin
        m_mag[0][0] = w_q[0][QX_A];  m_neg[0][0] = w_fl[0].neg_x;
        m_mag[0][1] = w_q[1][QX_A];  m_neg[0][1] = w_fl[1].neg_x;
        m_mag[1][0] = w_q[0][QY_A];  m_neg[1][0] = w_fl[0].neg_y;
        m_mag[1][1] = w_q[1][QY_A];  m_neg[1][1] = w_fl[1].neg_y;
        m_mag[2][0] = w_q[0][QX_B];  m_neg[2][0] = !w_fl[0].neg_x;
        m_mag[2][1] = w_q[2][QX_A];  m_neg[2][1] = w_fl[2].neg_x;
        m_mag[3][0] = w_q[0][QY_B];  m_neg[3][0] = !w_fl[0].neg_y;
        m_mag[3][1] = w_q[2][QY_A];  m_neg[3][1] = w_fl[2].neg_y;
        m_mag[4][0] = w_q[1][QX_B];  m_neg[4][0] = !w_fl[1].neg_x;
        m_mag[4][1] = w_q[2][QX_B];  m_neg[4][1] = !w_fl[2].neg_x;
        m_mag[5][0] = w_q[1][QY_B];  m_neg[5][0] = !w_fl[1].neg_y;
        m_mag[5][1] = w_q[2][QY_B];  m_neg[5][1] = !w_fl[2].neg_y;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            m_zero[p] = w_fl[p].zero;
        end
    end

    tbga_merge #(.MAG_BITS(QW)) u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_vld[VLD_N-1]),
        .i_mag  (m_mag),
        .i_neg  (m_neg),
        .i_zero (m_zero),
        .o_valid(o_res_valid),
        .o_res  (o_res)
    );

    always_comb begin
        at_limit = (o_res.acc_x_one == ACC_MAX) || (o_res.acc_x_one == ACC_MIN) ||
                   (o_res.acc_y_one == ACC_MAX) || (o_res.acc_y_one == ACC_MIN) ||
                   (o_res.acc_x_two == ACC_MAX) || (o_res.acc_x_two == ACC_MIN) ||
                   (o_res.acc_y_two == ACC_MAX) || (o_res.acc_y_two == ACC_MIN) ||
                   (o_res.acc_x_three == ACC_MAX) || (o_res.acc_x_three == ACC_MIN) ||
                   (o_res.acc_y_three == ACC_MAX) || (o_res.acc_y_three == ACC_MIN);
    end

    `TBGA_ASSERT(a_res_has_req, i_clk, i_rst_n, o_res_valid |-> $past(accept, LAT), "result without request")
    `TBGA_ASSERT(a_sat_at_limit, i_clk, i_rst_n, o_res_valid && o_res.saturated_flag |-> at_limit, "saturation flag without clipped value")
    `TBGA_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !o_res_valid, "result strobe after reset")
endmodule
`default_nettype wire

[hw/rtl/tbga_isqrt.sv]
`default_nettype none
module tbga_isqrt import tbga_pkg::*; #(
    parameter int IN_W = 66
) (
    input  wire logic                i_clk,
    input  wire logic [IN_W-1:0]     i_rad,
    output logic      [IN_W/2-1:0]   o_root
);
    localparam int OW = IN_W / 2;
    localparam int RW = OW + 2;

    logic [RW-1:0]   r_rem  [OW];
    logic [OW-1:0]   r_root [OW];
    logic [IN_W-1:0] r_rad  [OW];
    logic [RW-1:0]   s_rem  [OW];
    logic [OW-1:0]   s_root [OW];
    logic [IN_W-1:0] s_rad  [OW];
    logic [RW-1:0]   n_rem  [OW];
    logic [OW-1:0]   n_root [OW];
    logic [IN_W-1:0] n_rad  [OW];
    logic [RW+1:0]   cand   [OW];
    logic [RW+1:0]   trial  [OW];
    logic [RW+1:0]   diff   [OW];
    logic            fit    [OW];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        for (int k = 1; k < OW; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_rad[k]  = r_rad[k-1];
        end
        // one root bit per stage: bring down two radicand bits, try 4*root+1
        for (int k = 0; k < OW; k++) begin
            cand[k]   = {s_rem[k], s_rad[k][IN_W-1:IN_W-2]};
            trial[k]  = (RW+2)'({s_root[k], 2'b01});
            diff[k]   = cand[k] - trial[k];
            fit[k]    = (cand[k] >= trial[k]);
            n_rem[k]  = fit[k] ? diff[k][RW-1:0] : cand[k][RW-1:0];
            n_root[k] = {s_root[k][OW-2:0], fit[k]};
            n_rad[k]  = s_rad[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
    end

    assign o_root = r_root[OW-1];
endmodule
`default_nettype wire

[hw/rtl/tbga_div.sv]
`default_nettype none
module tbga_div import tbga_pkg::*; #(
    parameter int NUM_W = 112,
    parameter int DEN_W = 99
) (
    input  wire logic             i_clk,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);
    // remainder and shifting numerator/quotient word, one quotient bit per stage
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_d   [NUM_W];
    logic [DEN_W-1:0] s_rem [NUM_W];
    logic [NUM_W-1:0] s_nq  [NUM_W];
    logic [DEN_W-1:0] s_d   [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_nq  [NUM_W];
    logic [DEN_W:0]   cand  [NUM_W];
    logic [DEN_W:0]   diff  [NUM_W];
    logic             fit   [NUM_W];

    always_comb begin
        s_rem[0] = '0;
        s_nq[0]  = i_num;
        s_d[0]   = i_den;
        for (int k = 1; k < NUM_W; k++) begin
            s_rem[k] = r_rem[k-1];
            s_nq[k]  = r_nq[k-1];
            s_d[k]   = r_d[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            cand[k]  = {s_rem[k], s_nq[k][NUM_W-1]};
            diff[k]  = cand[k] - {1'b0, s_d[k]};
            fit[k]   = (cand[k] >= {1'b0, s_d[k]});
            n_rem[k] = fit[k] ? diff[k][DEN_W-1:0] : cand[k][DEN_W-1:0];
            n_nq[k]  = {s_nq[k][NUM_W-2:0], fit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_nq  <= n_nq;
        r_d   <= s_d;
    end

    assign o_quo = r_nq[NUM_W-1];
endmodule
`default_nettype wire

[hw/rtl/tbga_lane.sv]
`default_nettype none
module tbga_lane import tbga_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic signed [POS_W-1:0]       i_pa_x,
    input  wire logic signed [POS_W-1:0]       i_pa_y,
    input  wire logic signed [POS_W-1:0]       i_pb_x,
    input  wire logic signed [POS_W-1:0]       i_pb_y,
    input  wire logic [GM_W-1:0]               i_gm_a,
    input  wire logic [GM_W-1:0]               i_gm_b,
    output logic [PROD_W+FRAC_BITS-1:0]        o_quo [NUM_QUO],
    output t_pair_flags                        o_flags
);
    localparam int QW      = PROD_W + FRAC_BITS;
    localparam int HALF    = GM_W / 2;
    localparam int NUM_DLY = ROOT_W + 3;
    localparam int FLG_DLY = NUM_DLY + QW;

    logic [POS_W:0]      diff_x, diff_y;
    logic [POS_W:0]      abs_x, abs_y;
    logic [MAG_W-1:0]    r_s1_ux, r_s1_uy;
    logic                r_s1_nx, r_s1_ny;

    logic [GM_W-1:0]     sel_gm [NUM_QUO];
    logic [MAG_W-1:0]    sel_u  [NUM_QUO];
    logic [2*MAG_W-1:0]  r_s2_sqx, r_s2_sqy;
    logic [HALF+MAG_W-1:0] r_s2_plo [NUM_QUO];
    logic [HALF+MAG_W-1:0] r_s2_phi [NUM_QUO];
    t_pair_flags         r_s2_fl;

    logic [SUM_W-1:0]    r_s3_sum;
    logic [PROD_W-1:0]   r_s3_num [NUM_QUO];
    t_pair_flags         r_s3_fl;

    logic [ROOT_W-1:0]   w_root;
    logic [ROOT_W-1:0]   r_root1;
    logic [2*ROOT_W-1:0] r_rr;
    logic [2*ROOT_W-1:0] r_cp_lo, r_cp_hi;
    logic [CUBE_W-1:0]   r_cube;

    logic [PROD_W-1:0]   r_dl_num [NUM_DLY][NUM_QUO];
    t_pair_flags         r_dl_fl  [FLG_DLY];
    logic [QW-1:0]       w_quo    [NUM_QUO];

    always_comb begin
        diff_x = {i_pb_x[POS_W-1], i_pb_x} - {i_pa_x[POS_W-1], i_pa_x};
        diff_y = {i_pb_y[POS_W-1], i_pb_y} - {i_pa_y[POS_W-1], i_pa_y};
        abs_x  = diff_x[POS_W] ? ((POS_W+1)'(0) - diff_x) : diff_x;
        abs_y  = diff_y[POS_W] ? ((POS_W+1)'(0) - diff_y) : diff_y;
        // body a is pulled by mass b, body b by mass a
        sel_gm[QX_A] = i_gm_b;
        sel_gm[QY_A] = i_gm_b;
        sel_gm[QX_B] = i_gm_a;
        sel_gm[QY_B] = i_gm_a;
        sel_u[QX_A]  = r_s1_ux;
        sel_u[QY_A]  = r_s1_uy;
        sel_u[QX_B]  = r_s1_ux;
        sel_u[QY_B]  = r_s1_uy;
    end

    always_ff @(posedge i_clk) begin
        r_s1_ux <= abs_x[MAG_W-1:0];
        r_s1_uy <= abs_y[MAG_W-1:0];
        r_s1_nx <= diff_x[POS_W];
        r_s1_ny <= diff_y[POS_W];

        r_s2_sqx      <= r_s1_ux * r_s1_ux;
        r_s2_sqy      <= r_s1_uy * r_s1_uy;
        r_s2_fl.neg_x <= r_s1_nx;
        r_s2_fl.neg_y <= r_s1_ny;
        r_s2_fl.zero  <= (r_s1_ux == '0) && (r_s1_uy == '0);
        for (int q = 0; q < NUM_QUO; q++) begin
            r_s2_plo[q] <= sel_gm[q][HALF-1:0] * sel_u[q];
            r_s2_phi[q] <= sel_gm[q][GM_W-1:HALF] * sel_u[q];
        end

        r_s3_sum <= SUM_W'(r_s2_sqx) + SUM_W'(r_s2_sqy);
        r_s3_fl  <= r_s2_fl;
        for (int q = 0; q < NUM_QUO; q++) begin
            r_s3_num[q] <= {r_s2_phi[q], HALF'(0)} + PROD_W'(r_s2_plo[q]);
        end

        // r^3 in two halves of the second product
        r_root1 <= w_root;
        r_rr    <= w_root * w_root;
        r_cp_lo <= r_rr[ROOT_W-1:0] * r_root1;
        r_cp_hi <= r_rr[2*ROOT_W-1:ROOT_W] * r_root1;
        r_cube  <= CUBE_W'(r_cp_lo) + {r_cp_hi, ROOT_W'(0)};

        r_dl_num[0] <= r_s3_num;
        for (int k = 1; k < NUM_DLY; k++) begin
            r_dl_num[k] <= r_dl_num[k-1];
        end
        r_dl_fl[0] <= r_s3_fl;
        for (int k = 1; k < FLG_DLY; k++) begin
            r_dl_fl[k] <= r_dl_fl[k-1];
        end
    end

    tbga_isqrt #(
        .IN_W(SUM_W)
    ) u_isqrt (
        .i_clk (i_clk),
        .i_rad (r_s3_sum),
        .o_root(w_root)
    );

    for (genvar q = 0; q < NUM_QUO; q++) begin : g_div
        tbga_div #(
            .NUM_W(QW),
            .DEN_W(CUBE_W)
        ) u_div (
            .i_clk(i_clk),
            .i_num({r_dl_num[NUM_DLY-1][q], FRAC_BITS'(0)}),
            .i_den(r_cube),
            .o_quo(w_quo[q])
        );
        // coincident bodies contribute nothing
        assign o_quo[q] = w_quo[q] & {QW{~r_dl_fl[FLG_DLY-1].zero}};
    end

    assign o_flags = r_dl_fl[FLG_DLY-1];
endmodule
`default_nettype wire

[hw/rtl/tbga_merge.sv]
`default_nettype none
module tbga_merge import tbga_pkg::*; #(
    parameter int MAG_BITS = 112
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [MAG_BITS-1:0] i_mag  [NUM_ACC][NUM_TERMS],
    input  wire logic                i_neg  [NUM_ACC][NUM_TERMS],
    input  wire logic                i_zero [NUM_PAIRS],
    output logic                     o_valid,
    output t_res                     o_res
);
    localparam int SW = MAG_BITS + 2;

    logic [SW-1:0]      ext   [NUM_ACC][NUM_TERMS];
    logic [SW-1:0]      term  [NUM_ACC][NUM_TERMS];
    logic [SW-1:0]      n_sum [NUM_ACC];
    logic [SW-1:0]      r_sum [NUM_ACC];
    logic               n_coll, r_coll, r_vld;
    logic [SW-POS_W:0]  top   [NUM_ACC];
    logic               clip  [NUM_ACC];
    logic [POS_W-1:0]   acc   [NUM_ACC];
    logic               any_clip;
    t_res               n_res, r_res;
    logic               r_out_vld;

    always_comb begin
        n_coll = 1'b0;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            n_coll = n_coll | i_zero[p];
        end
        for (int a = 0; a < NUM_ACC; a++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                ext[a][t]  = SW'(i_mag[a][t]);
                term[a][t] = i_neg[a][t] ? (SW'(0) - ext[a][t]) : ext[a][t];
            end
            n_sum[a] = term[a][0] + term[a][1];
        end

        // clip where the sign bit of a 32-bit word and the bits above it disagree
        any_clip = 1'b0;
        for (int a = 0; a < NUM_ACC; a++) begin
            top[a]  = r_sum[a][SW-1:POS_W-1];
            clip[a] = !((top[a] == '0) || (top[a] == '1));
            acc[a]  = clip[a] ? (r_sum[a][SW-1] ? ACC_MIN : ACC_MAX) : r_sum[a][POS_W-1:0];
            any_clip = any_clip | clip[a];
        end
        n_res.acc_x_one      = acc[0];
        n_res.acc_y_one      = acc[1];
        n_res.acc_x_two      = acc[2];
        n_res.acc_y_two      = acc[3];
        n_res.acc_x_three    = acc[4];
        n_res.acc_y_three    = acc[5];
        n_res.collision_flag = r_coll;
        n_res.saturated_flag = any_clip;
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_coll <= n_coll;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= i_valid;
            r_out_vld <= r_vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_res;
endmodule
`default_nettype wire

[tb/sv/tb_three_body_gravity_accel.sv]
`default_nettype none
module tb_three_body_gravity_accel;
    import tbga_pkg::*;

    localparam int LATENCY = 153;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_RANDOM = 1400;

    typedef enum int {
        PH_STREAM,
        PH_SEND_IDLE,
        PH_RECV_IDLE,
        PH_BOTH_IDLE
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_res_valid;
    t_res o_res;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    three_body_gravity_accel uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_res_valid(o_res_valid), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [31:0] mass_reg [4];

    t_req pending_reqs [$];
    t_res accel_expect [$];
    int send_idle_pct = 0;
    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_collisions = 0;
    int n_saturations = 0;
    int idle_cycles = 0;

    // signed 161-bit accumulator keeps each body's sum exact before clipping
    function automatic void add_pull(input logic signed [31:0] xi, input logic signed [31:0] yi,
                                     input logic signed [31:0] xj, input logic signed [31:0] yj,
                                     input logic [31:0] mj,
                                     inout logic signed [160:0] ax,
                                     inout logic signed [160:0] ay, inout logic coll);
        logic signed [33:0] dx, dy;
        logic [32:0] ux, uy;
        logic [66:0] s;
        logic [33:0] r, c;
        logic [127:0] r3, gm, nx, ny;
        dx = 34'(xj) - 34'(xi);
        dy = 34'(yj) - 34'(yi);
        ux = dx < 0 ? 33'(-dx) : 33'(dx);
        uy = dy < 0 ? 33'(-dy) : 33'(dy);
        s = 67'(ux) * 67'(ux) + 67'(uy) * 67'(uy);
        if (s == 0) begin
            coll = 1'b1;
            return;
        end
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= 68'(s)) r = c;
        end
        r3 = 128'(r) * 128'(r) * 128'(r);
        gm = 128'(mass_reg[REG_GRAV]) * 128'(mj);
        nx = ((gm * 128'(ux)) << 16) / r3;
        ny = ((gm * 128'(uy)) << 16) / r3;
        if (dx < 0) ax = ax - $signed({33'd0, nx});
        else ax = ax + $signed({33'd0, nx});
        if (dy < 0) ay = ay - $signed({33'd0, ny});
        else ay = ay + $signed({33'd0, ny});
    endfunction

    function automatic logic [31:0] clip_accel(input logic signed [160:0] a, inout logic sat);
        if (a > 161'sh7FFF_FFFF) begin
            sat = 1'b1;
            return ACC_MAX;
        end
        if (a < -161'sh8000_0000) begin
            sat = 1'b1;
            return ACC_MIN;
        end
        return a[31:0];
    endfunction

    function automatic t_res predict_accel(input t_req q);
        logic signed [160:0] a [6];
        logic coll, sat;
        t_res res;
        coll = 1'b0;
        sat = 1'b0;
        for (int i = 0; i < 6; i++) a[i] = '0;
        add_pull(q.pos_x_one, q.pos_y_one, q.pos_x_two, q.pos_y_two,
                 mass_reg[REG_MASS_TWO], a[0], a[1], coll);
        add_pull(q.pos_x_one, q.pos_y_one, q.pos_x_three, q.pos_y_three,
                 mass_reg[REG_MASS_THREE], a[0], a[1], coll);
        add_pull(q.pos_x_two, q.pos_y_two, q.pos_x_one, q.pos_y_one,
                 mass_reg[REG_MASS_ONE], a[2], a[3], coll);
        add_pull(q.pos_x_two, q.pos_y_two, q.pos_x_three, q.pos_y_three,
                 mass_reg[REG_MASS_THREE], a[2], a[3], coll);
        add_pull(q.pos_x_three, q.pos_y_three, q.pos_x_one, q.pos_y_one,
                 mass_reg[REG_MASS_ONE], a[4], a[5], coll);
        add_pull(q.pos_x_three, q.pos_y_three, q.pos_x_two, q.pos_y_two,
                 mass_reg[REG_MASS_TWO], a[4], a[5], coll);
        res.acc_x_one = clip_accel(a[0], sat);
        res.acc_y_one = clip_accel(a[1], sat);
        res.acc_x_two = clip_accel(a[2], sat);
        res.acc_y_two = clip_accel(a[3], sat);
        res.acc_x_three = clip_accel(a[4], sat);
        res.acc_y_three = clip_accel(a[5], sat);
        res.collision_flag = coll;
        res.saturated_flag = sat;
        return res;
    endfunction

    // driver: present the head request, hold start while it waits
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                accel_expect.push_back(predict_accel(i_req));
                n_accepted <= n_accepted + 1;
            end
            if ((!start || !busy) && pending_reqs.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (accel_expect.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                n_errors++;
            end else begin
                t_res e;
                e = accel_expect.pop_front();
                n_results++;
                if (e.collision_flag) n_collisions++;
                if (e.saturated_flag) n_saturations++;
                if (e.acc_x_one !== o_res.acc_x_one)
                    $display("%0t: acc_x_one exp %h got %h", $time, e.acc_x_one, o_res.acc_x_one);
                if (e.acc_y_one !== o_res.acc_y_one)
                    $display("%0t: acc_y_one exp %h got %h", $time, e.acc_y_one, o_res.acc_y_one);
                if (e.acc_x_two !== o_res.acc_x_two)
                    $display("%0t: acc_x_two exp %h got %h", $time, e.acc_x_two, o_res.acc_x_two);
                if (e.acc_y_two !== o_res.acc_y_two)
                    $display("%0t: acc_y_two exp %h got %h", $time, e.acc_y_two, o_res.acc_y_two);
                if (e.acc_x_three !== o_res.acc_x_three)
                    $display("%0t: acc_x_three exp %h got %h", $time, e.acc_x_three,
                             o_res.acc_x_three);
                if (e.acc_y_three !== o_res.acc_y_three)
                    $display("%0t: acc_y_three exp %h got %h", $time, e.acc_y_three,
                             o_res.acc_y_three);
                if (e.collision_flag !== o_res.collision_flag)
                    $display("%0t: collision_flag exp %b got %b", $time, e.collision_flag,
                             o_res.collision_flag);
                if (e.saturated_flag !== o_res.saturated_flag)
                    $display("%0t: saturated_flag exp %b got %b", $time, e.saturated_flag,
                             o_res.saturated_flag);
                if (e !== o_res) n_errors++;
            end
        end
    end

    // watchdog: count cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("three_body_gravity_accel: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mass_reg[idx] = val;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || accel_expect.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos(input int spread);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return $signed($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        int spread;
        spread = 1 << $urandom_range(31, 4);
        if (spread <= 0) spread = 32'h3FFF_FFFF;
        q.pos_x_one = rand_pos(spread);
        q.pos_y_one = rand_pos(spread);
        q.pos_x_two = rand_pos(spread);
        q.pos_y_two = rand_pos(spread);
        q.pos_x_three = rand_pos(spread);
        q.pos_y_three = rand_pos(spread);
        // sometimes stack two bodies, or put one close to another
        case ($urandom_range(11))
            0: {q.pos_x_two, q.pos_y_two} = {q.pos_x_one, q.pos_y_one};
            1: {q.pos_x_three, q.pos_y_three} = {q.pos_x_two, q.pos_y_two};
            2: {q.pos_x_three, q.pos_y_three} = {q.pos_x_one + $urandom_range(2),
                                                 q.pos_y_one - $urandom_range(2)};
            default: ;
        endcase
        return q;
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return RESET_ONE;
            default: return $urandom_range(32'h0010_0000);
        endcase
    endfunction

    initial begin
        t_req q;
        mass_reg[REG_MASS_ONE] = RESET_ONE;
        mass_reg[REG_MASS_TWO] = RESET_ONE;
        mass_reg[REG_MASS_THREE] = RESET_ONE;
        mass_reg[REG_GRAV] = RESET_ONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unit triangle, coincidences, extremes
        q = '0;
        q.pos_x_two = 32'h0001_0000;
        q.pos_y_three = 32'h0001_0000;
        pending_reqs.push_back(q);
        pending_reqs.push_back('0);
        q = '0;
        q.pos_x_three = 32'h0002_0000;
        pending_reqs.push_back(q);
        q = '0;
        q.pos_x_two = 1;
        q.pos_y_three = -1;
        pending_reqs.push_back(q);
        pending_reqs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000});
        pending_reqs.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h0, 32'h0});
        pending_reqs.push_back('{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                 32'h5555_5555, 32'hAAAA_AAAA});
        pending_reqs.push_back('{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                                 32'h1234_5679, 32'h1234_5678});
        wait_drained();

        for (int setting = 0; setting < 7; setting++) begin
            case (setting)
                0: ;
                1: for (int r = 0; r < 4; r++) write_reg(2'(r), 32'hFFFF_FFFF);
                2: for (int r = 0; r < 4; r++) write_reg(2'(r), 32'h0);
                3: begin
                    write_reg(REG_MASS_ONE, 32'h0);
                    write_reg(REG_MASS_TWO, 32'h0000_8000);
                    write_reg(REG_MASS_THREE, 32'h0003_0000);
                    write_reg(REG_GRAV, 32'h0000_0001);
                end
                default: for (int r = 0; r < 4; r++) write_reg(2'(r), rand_mass());
            endcase
            for (int ph = PH_STREAM; ph <= PH_BOTH_IDLE; ph++) begin
                case (ph)
                    PH_SEND_IDLE: send_idle_pct = 82;
                    PH_BOTH_IDLE: send_idle_pct = 11;
                    default: send_idle_pct = 0;
                endcase
                for (int k = 0; k < NUM_RANDOM / 28; k++) pending_reqs.push_back(rand_req());
                while (pending_reqs.size() > 0) @(posedge i_clk);
            end
            wait_drained();
        end

        $display("covered %0d requests over 7 register settings, %0d results checked",
                 n_accepted, n_results);
        $display("%0d results with coincident bodies, %0d with clipped acceleration",
                 n_collisions, n_saturations);
        if (n_errors == 0) begin
            $display("three_body_gravity_accel: match");
        end else begin
            $display("three_body_gravity_accel: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/tbga_pkg.sv
hw/rtl/tbga_isqrt.sv
hw/rtl/tbga_div.sv
hw/rtl/tbga_lane.sv
hw/rtl/tbga_merge.sv
hw/rtl/three_body_gravity_accel.sv
tb/sv/tb_three_body_gravity_accel.sv
